@@ rtl/hvn_pkg.sv @@
// Package for the heightmap vertex normal core: grid sizes, vector types,
// operation codes and the status struct of the normalizer. No dependencies.
package hvn_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_LENGTH = 128;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 7;
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_LENGTH;
    localparam int DIM_W      = 8;
    localparam int H_W        = 8;

    // Vector component before normalizing (face normal or sum of unit normals).
    localparam int COMP_W = 18;
    localparam int MAG_W  = COMP_W - 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int DEN_W  = SQ_W + 1;
    localparam int QUO_W  = 31;
    localparam int ROOT_W = 16;
    localparam int Q_W    = 16;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
    localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] LEN_MAX   = DIM_W'(MAX_LENGTH);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    // Index 0 is x, 1 is y, 2 is z; components are two's complement.
    typedef logic [2:0][COMP_W-1:0] vec_t;
    typedef logic [2:0][Q_W-1:0]    res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } nu_stat_t;

endpackage

@@ rtl/heightmap_vertex_normals_core.sv @@
// Top level of the heightmap vertex normal core: height store, neighbor gather,
// face sequencing and output register. Depends on hvn_pkg, hvn_ram and hvn_norm.
//
//  channel  | direction | content
//  s_*      | in        | tdata: height_sample, col_x, row_z; tuser: operation
//  m_*      | out       | tdata: normal_x, normal_y, normal_z; tuser: coord_error
//  cfg_*    | in        | grid_width (index 0), grid_length (index 1)
//
// A query reads five heights from the single-port store, then the shared
// normalizer runs once per face that has both neighbors and once for the sum.
// Stores are taken while a query is being normalized.
// Reset clears control only; heights read before being written are undefined.
// A full output register stalls the face sequencer until m_tready.
module heightmap_vertex_normals_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // height_sample[7:0], col_x[14:8], row_z[21:15]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // normal_x[15:0], normal_y[31:16], normal_z[47:32]
    output logic [0:0]  m_tuser,   // coord_error[0]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [hvn_pkg::DIM_W-1:0] cfg_data
);
    import hvn_pkg::*;

    typedef enum logic [4:0] {
        G_IDLE = 5'b00001,
        G_W    = 5'b00010,
        G_S    = 5'b00100,
        G_E    = 5'b01000,
        G_N    = 5'b10000
    } gst_t;

    typedef enum logic [5:0] {
        CAP_NONE = 6'b000001,
        CAP_C    = 6'b000010,
        CAP_W    = 6'b000100,
        CAP_S    = 6'b001000,
        CAP_E    = 6'b010000,
        CAP_N    = 6'b100000
    } cap_t;

    typedef enum logic [5:0] {
        C_IDLE  = 6'b000001,
        C_FACE  = 6'b000010,
        C_WAIT  = 6'b000100,
        C_FINAL = 6'b001000,
        C_FWAIT = 6'b010000,
        C_OUT   = 6'b100000
    } cst_t;

    // Configuration
    logic [DIM_W-1:0] width_reg, length_reg, w_eff, l_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_MAX;
            length_reg <= LEN_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index[0])
                REG_WIDTH:  width_reg <= cfg_data;
                REG_LENGTH: length_reg <= cfg_data;
                default:    width_reg <= width_reg;
            endcase
        end
    end

    assign w_eff = (width_reg < DIM_MIN) ? DIM_MIN : (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
    assign l_eff = (length_reg < DIM_MIN) ? DIM_MIN : (length_reg > LEN_MAX) ? LEN_MAX : length_reg;

    // Input word
    logic             in_op, in_inside, acc, acc_query;
    logic [H_W-1:0]   in_h;
    logic [COL_W-1:0] in_x;
    logic [ROW_W-1:0] in_z;
    logic [3:0]       in_has;

    assign in_op = s_tuser[0];
    assign in_h = s_tdata[7:0];
    assign in_x = s_tdata[14:8];
    assign in_z = s_tdata[21:15];
    assign in_inside = ({1'b0, in_x} < w_eff) && ({1'b0, in_z} < l_eff);
    // Neighbor order: west, south, east, north.
    assign in_has[0] = in_x != '0;
    assign in_has[1] = ({1'b0, in_z} + 1'b1) < l_eff;
    assign in_has[2] = ({1'b0, in_x} + 1'b1) < w_eff;
    assign in_has[3] = in_z != '0;

    // Gather
    gst_t gather_reg, gather_next;
    cap_t cap_reg, cap_next;
    logic job_full_reg, job_full_next, gathering, job_take;
    logic [COL_W-1:0] qx_reg;
    logic [ROW_W-1:0] qz_reg;
    logic [3:0]       qhas_reg;
    logic             qerr_reg;
    logic [H_W-1:0]   hc_reg, hw_reg, hs_reg, he_reg, hn_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [H_W-1:0]    mem_rdata;

    assign gathering = (gather_reg != G_IDLE) || (cap_reg != CAP_NONE);
    assign s_tready = !gathering && (in_op == OP_STORE || !job_full_reg);
    assign acc = s_tvalid && s_tready;
    assign acc_query = acc && (in_op == OP_QUERY);
    assign mem_we = acc && (in_op == OP_STORE) && in_inside;

    always_comb
    begin
        unique case (gather_reg)
            G_IDLE:  mem_addr = {in_z, in_x};
            G_W:     mem_addr = {qz_reg, qx_reg - 1'b1};
            G_S:     mem_addr = {qz_reg + 1'b1, qx_reg};
            G_E:     mem_addr = {qz_reg, qx_reg + 1'b1};
            G_N:     mem_addr = {qz_reg - 1'b1, qx_reg};
            default: mem_addr = {in_z, in_x};
        endcase
    end

    always_comb
    begin
        gather_next = gather_reg;
        cap_next = CAP_NONE;
        unique case (gather_reg)
            G_IDLE:
            begin
                if (acc_query)
                begin
                    gather_next = G_W;
                    cap_next = CAP_C;
                end
            end
            G_W:
            begin
                gather_next = G_S;
                cap_next = CAP_W;
            end
            G_S:
            begin
                gather_next = G_E;
                cap_next = CAP_S;
            end
            G_E:
            begin
                gather_next = G_N;
                cap_next = CAP_E;
            end
            G_N:
            begin
                gather_next = G_IDLE;
                cap_next = CAP_N;
            end
            default:
            begin
                gather_next = G_IDLE;
            end
        endcase
    end

    assign job_full_next = (cap_reg == CAP_N) ? 1'b1 : (job_take ? 1'b0 : job_full_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg <= G_IDLE;
            cap_reg <= CAP_NONE;
            job_full_reg <= 1'b0;
        end
        else
        begin
            gather_reg <= gather_next;
            cap_reg <= cap_next;
            job_full_reg <= job_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_query)
        begin
            qx_reg <= in_x;
            qz_reg <= in_z;
            qhas_reg <= in_has;
            qerr_reg <= !in_inside;
        end
        unique case (cap_reg)
            CAP_C:    hc_reg <= mem_rdata;
            CAP_W:    hw_reg <= mem_rdata;
            CAP_S:    hs_reg <= mem_rdata;
            CAP_E:    he_reg <= mem_rdata;
            CAP_N:    hn_reg <= mem_rdata;
            default:  hc_reg <= hc_reg;
        endcase
    end

    hvn_ram #(
        .WIDTH (H_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (in_h),
        .rdata (mem_rdata)
    );

    // Face sequencing
    cst_t ctl_reg, ctl_next;
    logic [1:0]  fidx_reg, fidx_next;
    logic [3:0]  fhas_reg;
    logic        cerr_reg;
    logic [COMP_W-1:0] dw_reg, ds_reg, de_reg, dn_reg;
    vec_t sum_reg, face_vec, u_vec;
    res_t res_reg, u_res;
    nu_stat_t u_stat;
    logic face_ok, u_start, out_load;
    logic out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg;
    logic        out_err_reg;

    localparam logic [COMP_W-1:0] UP = COMP_W'(256);

    assign job_take = (ctl_reg == C_IDLE) && job_full_reg;
    assign face_ok = fhas_reg[fidx_reg] && fhas_reg[fidx_reg + 2'd1];

    // Each face normal reduces to (a, 256, b) in its neighbor pair.
    always_comb
    begin
        unique case (fidx_reg)
            2'd0:    face_vec = {-ds_reg, UP, dw_reg};
            2'd1:    face_vec = {-ds_reg, UP, -de_reg};
            2'd2:    face_vec = {dn_reg, UP, -de_reg};
            2'd3:    face_vec = {dn_reg, UP, dw_reg};
            default: face_vec = {dn_reg, UP, dw_reg};
        endcase
    end

    assign u_start = (ctl_reg == C_FACE && face_ok) || (ctl_reg == C_FINAL);
    assign u_vec = (ctl_reg == C_FINAL) ? sum_reg : face_vec;
    assign out_load = (ctl_reg == C_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        ctl_next = ctl_reg;
        fidx_next = fidx_reg;
        unique case (ctl_reg)
            C_IDLE:
            begin
                if (job_full_reg)
                begin
                    ctl_next = qerr_reg ? C_OUT : C_FACE;
                    fidx_next = 2'd0;
                end
            end
            C_FACE:
            begin
                if (face_ok)
                begin
                    ctl_next = C_WAIT;
                end
                else if (fidx_reg == 2'd3)
                begin
                    ctl_next = C_FINAL;
                end
                else
                begin
                    fidx_next = fidx_reg + 2'd1;
                end
            end
            C_WAIT:
            begin
                if (u_stat.done)
                begin
                    ctl_next = (fidx_reg == 2'd3) ? C_FINAL : C_FACE;
                    fidx_next = fidx_reg + 2'd1;
                end
            end
            C_FINAL:
            begin
                ctl_next = C_FWAIT;
            end
            C_FWAIT:
            begin
                if (u_stat.done)
                begin
                    ctl_next = C_OUT;
                end
            end
            C_OUT:
            begin
                if (out_load)
                begin
                    ctl_next = C_IDLE;
                end
            end
            default:
            begin
                ctl_next = C_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= C_IDLE;
            fidx_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            fidx_reg <= fidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            fhas_reg <= qhas_reg;
            cerr_reg <= qerr_reg;
            dw_reg <= COMP_W'($signed({1'b0, hw_reg}) - $signed({1'b0, hc_reg}));
            ds_reg <= COMP_W'($signed({1'b0, hs_reg}) - $signed({1'b0, hc_reg}));
            de_reg <= COMP_W'($signed({1'b0, he_reg}) - $signed({1'b0, hc_reg}));
            dn_reg <= COMP_W'($signed({1'b0, hn_reg}) - $signed({1'b0, hc_reg}));
            sum_reg <= '0;
            res_reg <= '0;
        end
        if (ctl_reg == C_WAIT && u_stat.done)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= sum_reg[k] + COMP_W'($signed(u_res[k]));
            end
        end
        if (ctl_reg == C_FWAIT && u_stat.done)
        begin
            res_reg <= u_res;
        end
        if (out_load)
        begin
            out_data_reg <= {Q_W'(-res_reg[2]), res_reg[1], res_reg[0]};
            out_err_reg <= cerr_reg;
        end
    end

    hvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (u_start),
        .vec   (u_vec),
        .stat  (u_stat),
        .res   (u_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser[0] = out_err_reg;

    a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (gather_reg == G_IDLE))
        else $error("store write during neighbor gather");

    a_query_slot: assert property (@(posedge clk) disable iff (!rst_n)
        acc_query |-> !job_full_reg && !gathering)
        else $error("query accepted while previous query not handed over");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        u_start |-> !u_stat.busy)
        else $error("normalizer started while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error word carries a nonzero normal");

endmodule

@@ rtl/hvn_ram.sv @@
// Generic single-port RAM with one write or read per cycle and registered read data.
// No dependencies.
module hvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/hvn_norm.sv @@
// Iterative vector normalizer: three lanes share one length, each lane divides
// and then takes a square root bit by bit. Depends on hvn_pkg.
module hvn_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  hvn_pkg::vec_t     vec,
    output hvn_pkg::nu_stat_t stat,
    output hvn_pkg::res_t     res
);
    import hvn_pkg::*;

    typedef enum logic [5:0] {
        U_IDLE = 6'b000001,
        U_SQ   = 6'b000010,
        U_SUM  = 6'b000100,
        U_DIV  = 6'b001000,
        U_ROOT = 6'b010000,
        U_DONE = 6'b100000
    } ust_t;

    ust_t st_reg, st_next;
    logic [4:0] cnt_reg, cnt_next;
    logic first_reg, first_next;

    logic [MAG_W-1:0]  mag_reg  [3];
    logic              neg_reg  [3];
    logic [SQ_W-1:0]   sq_reg   [3];
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg  [3];
    logic [QUO_W-1:0]  quo_reg  [3];
    logic [ROOT_W-1:0] root_reg [3];

    logic [DEN_W:0]      trial    [3];
    logic                ge       [3];
    logic [DEN_W-1:0]    rem_step [3];
    logic [ROOT_W-1:0]   cand     [3];
    logic [2*ROOT_W-1:0] cand_sq  [3];
    logic                fits     [3];
    logic [ROOT_W-1:0]   half     [3];
    logic [COMP_W-1:0]   absv     [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            absv[k] = vec[k][COMP_W-1] ? (~vec[k] + 1'b1) : vec[k];
            // The first step compares the numerator itself, later ones shift in a zero.
            trial[k] = first_reg ? {1'b0, rem_reg[k]} : {rem_reg[k], 1'b0};
            ge[k] = trial[k] >= {1'b0, den_reg};
            rem_step[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_reg}) : DEN_W'(trial[k]);
            cand[k] = root_reg[k] | (ROOT_W'(1) << cnt_reg[3:0]);
            cand_sq[k] = cand[k] * cand[k];
            fits[k] = cand_sq[k] <= {1'b0, quo_reg[k]};
            // Largest odd t with t*t <= quotient gives the rounded result (t+1)/2.
            half[k] = ROOT_W'(({1'b0, root_reg[k]} + 1'b1) >> 1);
            res[k] = neg_reg[k] ? Q_W'(~half[k] + 1'b1) : Q_W'(half[k]);
        end
    end

    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        first_next = first_reg;
        unique case (st_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    st_next = U_SQ;
                end
            end
            U_SQ:
            begin
                st_next = U_SUM;
            end
            U_SUM:
            begin
                st_next = U_DIV;
                cnt_next = 5'(QUO_W - 1);
                first_next = 1'b1;
            end
            U_DIV:
            begin
                first_next = 1'b0;
                if (cnt_reg == 5'd0)
                begin
                    st_next = U_ROOT;
                    cnt_next = 5'(ROOT_W - 1);
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            U_ROOT:
            begin
                if (cnt_reg == 5'd0)
                begin
                    st_next = U_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            U_DONE:
            begin
                st_next = U_IDLE;
            end
            default:
            begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= U_IDLE;
            cnt_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (st_reg == U_IDLE && start)
            begin
                mag_reg[k] <= absv[k][MAG_W-1:0];
                neg_reg[k] <= vec[k][COMP_W-1];
            end
            if (st_reg == U_SQ)
            begin
                sq_reg[k] <= mag_reg[k] * mag_reg[k];
            end
            if (st_reg == U_SUM)
            begin
                rem_reg[k] <= DEN_W'(sq_reg[k]);
                quo_reg[k] <= '0;
                root_reg[k] <= '0;
            end
            if (st_reg == U_DIV)
            begin
                rem_reg[k] <= rem_step[k];
                quo_reg[k] <= {quo_reg[k][QUO_W-2:0], ge[k]};
            end
            if (st_reg == U_ROOT && fits[k])
            begin
                root_reg[k] <= cand[k];
            end
        end
        if (st_reg == U_SUM)
        begin
            den_reg <= DEN_W'(sq_reg[0]) + DEN_W'(sq_reg[1]) + DEN_W'(sq_reg[2]);
        end
    end

    assign stat.busy = (st_reg != U_IDLE);
    assign stat.done = (st_reg == U_DONE);

endmodule

@@ sim/heightmap_vertex_normals_core_test.sv @@
// Testbench for heightmap_vertex_normals_core: stores heights, queries vertex normals
// and checks every result word against a built-in predictor. Depends on hvn_pkg and heightmap_vertex_normals_core.
`timescale 1ns / 100ps

module heightmap_vertex_normals_core_test;
    import hvn_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               err;
    } normal_word_t;

    typedef longint vec3_t[3];

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [DIM_W-1:0] cfg_data;

    // Predictor state.
    logic [7:0]   heights [0:DEPTH-1];
    bit           written [0:DEPTH-1];
    int           grid_w_raw;
    int           grid_l_raw;
    normal_word_t normals_due[$];

    int     mismatches;
    longint cycles;
    int     burst_left;
    bit     steady;
    int     hold_cycles;
    int     rx_mode;
    int     rx_mode_left;

    heightmap_vertex_normals_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int eff_dim(int v, int maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // Round of c * 16384 / sqrt(len2), ties away from zero, by bisection.
    function automatic longint unit_q14(longint c, longint unsigned len2);
        longint unsigned a;
        longint unsigned rhs;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        a = (c < 0) ? longint'(-c) : c;
        rhs = (a * a) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * len2 <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (c < 0) ? -longint'(lo) : longint'(lo);
    endfunction

    function automatic vec3_t unit_vec(vec3_t v);
        vec3_t u;
        longint unsigned len2;
        longint unsigned a;
        len2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            a = (v[k] < 0) ? longint'(-v[k]) : v[k];
            len2 += a * a;
        end
        for (int k = 0; k < 3; k++)
            u[k] = (len2 == 0) ? 0 : unit_q14(v[k], len2);
        return u;
    endfunction

    function automatic longint height_at(int x, int z);
        return longint'(heights[z * MAX_WIDTH + x]);
    endfunction

    function automatic normal_word_t vertex_normal(int x, int z);
        int ndx[4] = '{-1, 0, 1, 0};
        int ndz[4] = '{0, 1, 0, -1};
        normal_word_t r;
        int w;
        int l;
        int m;
        bit has[4];
        longint c;
        longint dh1;
        longint dh2;
        vec3_t n;
        vec3_t u;
        vec3_t sum;
        w = eff_dim(grid_w_raw, MAX_WIDTH);
        l = eff_dim(grid_l_raw, MAX_LENGTH);
        r.err = 1'b0;
        if (x >= w || z >= l)
        begin
            r.nx = 0;
            r.ny = 0;
            r.nz = 0;
            r.err = 1'b1;
            return r;
        end
        has[0] = x > 0;
        has[1] = z + 1 < l;
        has[2] = x + 1 < w;
        has[3] = z > 0;
        c = height_at(x, z);
        sum = '{0, 0, 0};
        for (int k = 0; k < 4; k++)
        begin
            m = (k + 1) & 3;
            if (has[k] && has[m])
            begin
                dh1 = height_at(x + ndx[k], z + ndz[k]) - c;
                dh2 = height_at(x + ndx[m], z + ndz[m]) - c;
                n[0] = dh1 * ndz[m] - ndz[k] * dh2;
                n[1] = 256 * (ndz[k] * ndx[m] - ndx[k] * ndz[m]);
                n[2] = ndx[k] * dh2 - dh1 * ndx[m];
                u = unit_vec(n);
                for (int j = 0; j < 3; j++)
                    sum[j] += u[j];
            end
        end
        u = unit_vec(sum);
        r.nx = u[0][15:0];
        r.ny = u[1][15:0];
        r.nz = 16'(-u[2]);
        return r;
    endfunction

    // Applies one accepted word to the predictor.
    function automatic void absorb_word(logic op, logic [7:0] smp, int x, int z);
        if (op == OP_STORE)
        begin
            if (x < eff_dim(grid_w_raw, MAX_WIDTH) && z < eff_dim(grid_l_raw, MAX_LENGTH))
            begin
                heights[z * MAX_WIDTH + x] = smp;
                written[z * MAX_WIDTH + x] = 1'b1;
            end
        end
        else
            normals_due.push_back(vertex_normal(x, z));
    endfunction

    task automatic send_word(logic op, logic [7:0] smp, int x, int z);
        int gap;
        if (!steady && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, 7'(z), 7'(x), smp};
        do
            @(posedge clk);
        while (!s_tready);
        absorb_word(op, smp, x, z);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (normals_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid(int w, int l);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= DIM_W'(w);
        @(posedge clk);
        cfg_index <= REG_LENGTH;
        cfg_data  <= DIM_W'(l);
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_w_raw = w & 8'hFF;
        grid_l_raw = l & 8'hFF;
    endtask

    function automatic logic [7:0] rand_height();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic store_if_blank(int x, int z);
        if (!written[z * MAX_WIDTH + x])
            send_word(OP_STORE, rand_height(), x, z);
    endtask

    // Makes sure every cell the query reads holds a height, then queries.
    task automatic query_cell(int x, int z);
        int w;
        int l;
        w = eff_dim(grid_w_raw, MAX_WIDTH);
        l = eff_dim(grid_l_raw, MAX_LENGTH);
        if (x < w && z < l)
        begin
            store_if_blank(x, z);
            if (x > 0)
                store_if_blank(x - 1, z);
            if (x + 1 < w)
                store_if_blank(x + 1, z);
            if (z > 0)
                store_if_blank(x, z - 1);
            if (z + 1 < l)
                store_if_blank(x, z + 1);
        end
        send_word(OP_QUERY, 8'($urandom_range(0, 255)), x, z);
    endtask

    task automatic test_directed;
        set_grid(128, 128);
        send_word(OP_STORE, 8'h00, 0, 0);
        send_word(OP_STORE, 8'hFF, 1, 0);
        send_word(OP_STORE, 8'h80, 0, 1);
        query_cell(0, 0);
        send_word(OP_STORE, 8'hFF, 127, 127);
        send_word(OP_STORE, 8'h00, 126, 127);
        send_word(OP_STORE, 8'h00, 127, 126);
        query_cell(127, 127);
        query_cell(0, 127);
        query_cell(127, 0);
        query_cell(64, 0);
        query_cell(0, 64);
        send_word(OP_STORE, 8'hFF, 40, 40);
        send_word(OP_STORE, 8'h00, 39, 40);
        send_word(OP_STORE, 8'h00, 41, 40);
        send_word(OP_STORE, 8'h00, 40, 39);
        send_word(OP_STORE, 8'h00, 40, 41);
        query_cell(40, 40);
        // A flat patch gives a straight up normal.
        send_word(OP_STORE, 8'h00, 40, 40);
        query_cell(40, 40);
        set_grid(16, 8);
        query_cell(16, 3);
        query_cell(3, 8);
        query_cell(127, 127);
        send_word(OP_STORE, 8'h55, 20, 2);
        query_cell(15, 7);
    endtask

    task automatic test_random(int w, int l, int n);
        int gw;
        int gl;
        int x;
        int z;
        int pick;
        set_grid(w, l);
        gw = eff_dim(w, MAX_WIDTH);
        gl = eff_dim(l, MAX_LENGTH);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            x = $urandom_range(0, gw - 1);
            z = $urandom_range(0, gl - 1);
            if (pick < 40)
                send_word(OP_STORE, rand_height(), x, z);
            else if (pick < 45)
                send_word(OP_STORE, rand_height(), $urandom_range(0, 127),
                          $urandom_range(0, 127));
            else if (pick < 90)
                query_cell(x, z);
            else
                query_cell($urandom_range(0, 127), $urandom_range(0, 127));
        end
    endtask

    task automatic test_backpressure;
        set_grid(12, 12);
        steady = 1'b1;
        hold_cycles = 3000;
        for (int i = 0; i < 60; i++)
        begin
            if (i % 3 == 0)
                query_cell($urandom_range(0, 11), $urandom_range(0, 11));
            else
                send_word(OP_STORE, rand_height(), $urandom_range(0, 11),
                          $urandom_range(0, 11));
        end
        steady = 1'b0;
    endtask

    task automatic test_pause;
        for (int i = 0; i < 10; i++)
            query_cell($urandom_range(0, 11), $urandom_range(0, 11));
        // Sender waits for every result before going on.
        s_tvalid <= 1'b0;
        while (normals_due.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 10; i++)
            query_cell($urandom_range(0, 11), $urandom_range(0, 11));
    endtask

    // Receiver: checks each word and drives m_tready on a pattern of its own.
    always @(posedge clk)
    begin
        normal_word_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (normals_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h/%b", $realtime,
                         m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                e = normals_due.pop_front();
                if ($signed(m_tdata[15:0]) != e.nx || $signed(m_tdata[31:16]) != e.ny
                    || $signed(m_tdata[47:32]) != e.nz || m_tuser[0] != e.err)
                begin
                    $display("%0t: mismatch, expected (%0d %0d %0d err %0b) actual (%0d %0d %0d err %0b)",
                             $realtime, e.nx, e.ny, e.nz, e.err, $signed(m_tdata[15:0]),
                             $signed(m_tdata[31:16]), $signed(m_tdata[47:32]), m_tuser[0]);
                    mismatches++;
                end
            end
        end
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 800);
        end
        else
            rx_mode_left--;
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        steady = 1'b0;
        hold_cycles = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        grid_w_raw = 128;
        grid_l_raw = 128;
        for (int i = 0; i < DEPTH; i++)
        begin
            heights[i] = 8'h00;
            written[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Queries also store their blank neighbors.
        test_directed();
        test_random(2, 2, 60);
        test_random(128, 2, 60);
        test_random(2, 128, 60);
        test_random(0, 1, 40);
        test_random(255, 200, 60);
        test_random($urandom_range(3, 20), $urandom_range(3, 20), 80);
        test_random($urandom_range(3, 20), $urandom_range(3, 20), 80);
        test_backpressure();
        test_pause();
        test_random(128, 128, 80);
        drain();

        if (mismatches == 0 && normals_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ heightmap_vertex_normals_core.f @@
rtl/hvn_pkg.sv
rtl/hvn_ram.sv
rtl/hvn_norm.sv
rtl/heightmap_vertex_normals_core.sv
sim/heightmap_vertex_normals_core_test.sv
